@@ rtl/smd_pkg.sv @@
// shared types and constants of the sha-1 message digest block
// holds the request structs, the round constants and the initial chaining values
// no dependencies
package smd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	// working variables a..e of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [6:0] ROUND_GROUP1 = 7'd20;
	localparam logic [6:0] ROUND_GROUP2 = 7'd40;
	localparam logic [6:0] ROUND_GROUP3 = 7'd60;
	localparam logic [6:0] LAST_ROUND   = 7'd79;
	localparam logic [6:0] SCHED_WORDS  = 7'd16;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [2:0] CV_WORDS  = 3'd5;
	localparam logic [2:0] LAST_WORD = 3'd4;

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0: v = 32'h67452301;
			3'd1: v = 32'hEFCDAB89;
			3'd2: v = 32'h98BADCFE;
			3'd3: v = 32'h10325476;
			default: v = 32'hC3D2E1F0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/smd_round.sv @@
// one sha-1 compression round: round function, constant and variable rotation
// depends on smd_pkg for work_t and the round constants
module smd_round
	import smd_pkg::*;
(
	input  work_t       cur,
	input  logic [31:0] w,
	input  logic [6:0]  rnd,
	output work_t       nxt
);

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] rol_a;

	always_comb begin
		if (rnd < ROUND_GROUP1) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K0;
		end else if (rnd < ROUND_GROUP2) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K1;
		end else if (rnd < ROUND_GROUP3) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K3;
		end
	end

	assign rol_a = {cur.a[26:0], cur.a[31:27]};

	always_comb begin
		nxt.a = rol_a + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

@@ rtl/sha1_message_digest.sv @@
// SHA-1 digest over a byte stream. Message bytes are taken one per cycle
// unless the input is stalled and packed into a 16-word block memory; a full
// block stalls the input while the chaining words are read, 80 rounds run
// at one per cycle (one round unit, the schedule in a 16-word shift line)
// and each chaining word is read, added to and written back. An end mark
// stalls the input while padding bytes go through the same byte path one
// per cycle (up to 72 of them), with one or two block compressions, then
// the five digest words leave in turn, each held until taken. The block
// memory has no reset and needs no clearing pass; the chaining memory reads
// as the initial values until the first block of a message is done.
// depends on smd_pkg and smd_round
module sha1_message_digest
	import smd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         msg_valid,
	output logic         msg_stall,
	input  msg_item_t    msg,
	output logic         digest_valid,
	input  logic         digest_stall,
	output digest_item_t digest
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_UPD   = 3'd4;
	localparam logic [2:0] S_ORD   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	localparam logic [1:0] PH_MARK = 2'd0;
	localparam logic [1:0] PH_ZERO = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	logic [2:0]  state_q;
	logic [1:0]  ph_q;
	logic        pad_q;
	logic        first_q;
	logic [60:0] count_q;
	logic [5:0]  pos_q;
	logic [63:0] len_q;
	logic [2:0]  lidx_q;
	logic [2:0]  idx_q;
	logic [6:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        out_valid_q;
	logic [23:0] word_q;

	logic [31:0] buf_mem [16];
	logic [31:0] buf_rd_q;
	logic [31:0] cv_mem [5];
	logic [31:0] cv_rd_q;

	logic [31:0] wk_q [5];
	logic [31:0] w_q [16];

	logic        msg_acc;
	logic        push_en;
	logic [7:0]  push_byte;
	logic        wrap;
	logic [3:0]  buf_addr;
	logic [2:0]  cv_addr;
	logic        cv_re;
	logic [2:0]  prev_idx;
	logic [31:0] cv_sel;
	logic [31:0] w_x;
	logic [31:0] w_new;
	work_t       cur_work;
	work_t       nxt_work;

	assign msg_stall = (state_q != S_IDLE);
	assign msg_acc   = msg_valid && !msg_stall;

	// byte path shared by message bytes and padding
	always_comb begin
		push_en   = 1'b0;
		push_byte = msg.data_byte;
		if (state_q == S_IDLE) begin
			push_en = msg_acc && msg.byte_valid;
		end else if (state_q == S_PAD) begin
			unique case (ph_q)
				PH_MARK: begin
					push_en   = 1'b1;
					push_byte = PAD_MARK;
				end
				PH_ZERO: begin
					push_en   = (pos_q != LEN_POS);
					push_byte = 8'h00;
				end
				PH_LEN: begin
					push_en   = 1'b1;
					push_byte = len_q[63:56];
				end
				default: begin
					push_en   = 1'b0;
					push_byte = 8'h00;
				end
			endcase
		end
	end

	assign wrap = push_en && (&pos_q);

	assign prev_idx = idx_q - 3'd1;
	assign cv_sel   = first_q ? iv_word(prev_idx) : cv_rd_q;

	always_comb begin
		cv_re   = 1'b0;
		cv_addr = idx_q;
		if (state_q == S_LOAD || state_q == S_UPD) begin
			cv_re = (idx_q < CV_WORDS);
		end else if (state_q == S_ORD) begin
			cv_re   = 1'b1;
			cv_addr = oidx_q;
		end
	end

	assign buf_addr = (state_q == S_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;

	// schedule: w_q[15] is the newest word, w_q[0] the word sixteen rounds back
	assign w_x   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = (rnd_q < SCHED_WORDS) ? buf_rd_q : {w_x[30:0], w_x[31]};

	assign cur_work = '{a: wk_q[0], b: wk_q[1], c: wk_q[2], d: wk_q[3], e: wk_q[4]};

	smd_round u_round (
		.cur (cur_work),
		.w   (w_new),
		.rnd (rnd_q),
		.nxt (nxt_work)
	);

	// block memory
	always_ff @(posedge clk) begin
		if (push_en && (&pos_q[1:0])) begin
			buf_mem[pos_q[5:2]] <= {word_q, push_byte};
		end
		buf_rd_q <= buf_mem[buf_addr];
	end

	// chaining memory, read then add and write back
	always_ff @(posedge clk) begin
		if (state_q == S_UPD && idx_q != 3'd0) begin
			cv_mem[prev_idx] <= cv_sel + wk_q[prev_idx];
		end
		if (cv_re) begin
			cv_rd_q <= cv_mem[cv_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (push_en) begin
			word_q <= {word_q[15:0], push_byte};
		end
		if (state_q == S_LOAD && idx_q != 3'd0) begin
			wk_q[prev_idx] <= cv_sel;
		end
		if (state_q == S_ROUND) begin
			wk_q[0] <= nxt_work.a;
			wk_q[1] <= nxt_work.b;
			wk_q[2] <= nxt_work.c;
			wk_q[3] <= nxt_work.d;
			wk_q[4] <= nxt_work.e;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
		if (state_q == S_IDLE && msg_acc && msg.end_of_message) begin
			len_q <= {count_q + 61'(msg.byte_valid), 3'b000};
		end else if (state_q == S_PAD && ph_q == PH_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_MARK;
			pad_q       <= 1'b0;
			first_q     <= 1'b1;
			count_q     <= '0;
			pos_q       <= '0;
			lidx_q      <= '0;
			idx_q       <= '0;
			rnd_q       <= '0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_en) begin
				pos_q <= pos_q + 6'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						if (msg.byte_valid) begin
							count_q <= count_q + 61'd1;
						end
						if (msg.end_of_message) begin
							pad_q <= 1'b1;
							ph_q  <= PH_MARK;
						end
						if (wrap) begin
							state_q <= S_LOAD;
							idx_q   <= '0;
						end else if (msg.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					unique case (ph_q)
						PH_MARK: begin
							ph_q <= PH_ZERO;
						end
						PH_ZERO: begin
							if (pos_q == LEN_POS) begin
								ph_q   <= PH_LEN;
								lidx_q <= '0;
							end
						end
						PH_LEN: begin
							lidx_q <= lidx_q + 3'd1;
							if (&lidx_q) begin
								ph_q <= PH_DONE;
							end
						end
						default: begin
							ph_q <= PH_DONE;
						end
					endcase
					if (wrap) begin
						state_q <= S_LOAD;
						idx_q   <= '0;
					end
				end
				S_LOAD: begin
					if (idx_q == CV_WORDS) begin
						state_q <= S_ROUND;
						idx_q   <= '0;
						rnd_q   <= '0;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= S_UPD;
						idx_q   <= '0;
					end
				end
				S_UPD: begin
					if (idx_q == CV_WORDS) begin
						idx_q   <= '0;
						first_q <= 1'b0;
						if (!pad_q) begin
							state_q <= S_IDLE;
						end else if (ph_q == PH_DONE) begin
							state_q <= S_ORD;
							oidx_q  <= '0;
						end else begin
							state_q <= S_PAD;
						end
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				S_ORD: begin
					state_q     <= S_EMIT;
					out_valid_q <= 1'b1;
				end
				S_EMIT: begin
					if (!digest_stall) begin
						out_valid_q <= 1'b0;
						if (oidx_q == LAST_WORD) begin
							// back to the reset state for the next message
							state_q <= S_IDLE;
							first_q <= 1'b1;
							pad_q   <= 1'b0;
							ph_q    <= PH_MARK;
							count_q <= '0;
							pos_q   <= '0;
							oidx_q  <= '0;
						end else begin
							state_q <= S_ORD;
							oidx_q  <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign digest_valid = out_valid_q;
	assign digest = '{
		digest_word: cv_rd_q,
		word_index:  oidx_q,
		last_word:   (oidx_q == LAST_WORD)
	};

	a_valid_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_EMIT))
		else $error("digest valid outside emit");

	a_wrap_starts_block: assert property (@(posedge clk) disable iff (!arst_n)
		wrap |=> (state_q == S_LOAD && idx_q == 3'd0))
		else $error("full block did not start compression");

	a_digest_after_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ORD) |-> (pad_q && ph_q == PH_DONE && !first_q && pos_q == 6'd0))
		else $error("digest read before padding finished");

	a_message_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && digest.last_word)
		|=> (state_q == S_IDLE && count_q == '0 && first_q))
		else $error("block not returned to reset state after digest");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD && ph_q == PH_LEN) |-> (pos_q[5:3] == 3'b111 && pos_q[2:0] == lidx_q))
		else $error("length byte out of place");

endmodule

@@ bench/tb.sv @@
// testbench of sha1_message_digest: directed and random byte-stream messages with a sha-1
// predictor in a scoreboard class, random gaps and stalls on both channels
// depends on smd_pkg and the rtl of sha1_message_digest
module tb
	import smd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AT_WORD = 25;
	localparam int RANDOM_ITEMS = 350;
	localparam int TAIL_CYCLES = 400;

	localparam logic [31:0] RC0 = 32'h5A827999;
	localparam logic [31:0] RC1 = 32'h6ED9EBA1;
	localparam logic [31:0] RC2 = 32'h8F1BBCDC;
	localparam logic [31:0] RC3 = 32'hCA62C1D6;

	class digest_checker;
		logic [31:0]  chain [5];
		logic [7:0]   block [64];
		logic [60:0]  byte_count;
		digest_item_t expected_words [$];
		int           errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			chain[0] = 32'h67452301;
			chain[1] = 32'hEFCDAB89;
			chain[2] = 32'h98BADCFE;
			chain[3] = 32'h10325476;
			chain[4] = 32'hC3D2E1F0;
			for (int i = 0; i < 64; i++) block[i] = 8'h00;
			byte_count = '0;
		endfunction

		// 80-round compression of the current block into the chain
		function void compress_block();
			logic [31:0] w [80];
			logic [31:0] a, b, c, d, e, f, k, t;
			for (int r = 0; r < 16; r++)
				w[r] = {block[4*r], block[4*r+1], block[4*r+2], block[4*r+3]};
			for (int r = 16; r < 80; r++) begin
				t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
				w[r] = {t[30:0], t[31]};
			end
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int r = 0; r < 80; r++) begin
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = RC0;
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = RC1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = RC2;
				end else begin
					f = b ^ c ^ d;
					k = RC3;
				end
				t = {a[26:0], a[31:27]} + f + e + k + w[r];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void take_request(msg_item_t m);
			int           pos;
			logic [63:0]  bits;
			digest_item_t di;
			if (m.byte_valid) begin
				pos = int'(byte_count[5:0]);
				block[pos] = m.data_byte;
				byte_count = byte_count + 1'b1;
				if (pos == 63) compress_block();
			end
			if (!m.end_of_message) return;
			pos = int'(byte_count[5:0]);
			block[pos] = 8'h80;
			for (int i = pos + 1; i < 64; i++) block[i] = 8'h00;
			// no room for the length: one extra block
			if (pos >= 56) begin
				compress_block();
				for (int i = 0; i < 64; i++) block[i] = 8'h00;
			end
			bits = {byte_count, 3'b000};
			for (int i = 0; i < 8; i++) block[56+i] = bits[63-8*i -: 8];
			compress_block();
			for (int i = 0; i < 5; i++) begin
				di.digest_word = chain[i];
				di.word_index = 3'(i);
				di.last_word = (i == 4);
				expected_words.push_back(di);
			end
			restart();
		endfunction

		function void check_word(digest_item_t got);
			digest_item_t want;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected digest word: expected none, actual %h index %0d last %0b",
					$time, got.digest_word, got.word_index, got.last_word);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (got.digest_word !== want.digest_word) begin
				$display("%0t: digest_word mismatch: expected %h, actual %h",
					$time, want.digest_word, got.digest_word);
				errors++;
			end
			if (got.word_index !== want.word_index) begin
				$display("%0t: word_index mismatch: expected %0d, actual %0d",
					$time, want.word_index, got.word_index);
				errors++;
			end
			if (got.last_word !== want.last_word) begin
				$display("%0t: last_word mismatch: expected %0b, actual %0b",
					$time, want.last_word, got.last_word);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         msg_valid;
	logic         msg_stall;
	msg_item_t    msg;
	logic         digest_valid;
	logic         digest_stall;
	digest_item_t digest;

	digest_checker checker_h;
	int            cycle_count = 0;
	int            random_items = 0;
	int            random_msgs = 0;
	int            words_taken = 0;

	sha1_message_digest dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sha1_message_digest test failed");
			$finish;
		end
	end

	task automatic send_request(input msg_item_t m, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg <= m;
		msg_valid <= 1'b1;
		do @(posedge clk); while (msg_stall);
		checker_h.take_request(m);
	endtask

	task automatic take_word(input int gap);
		@(negedge clk);
		if (gap > 0) begin
			digest_stall <= 1'b1;
			repeat (gap) @(negedge clk);
		end
		digest_stall <= 1'b0;
		do @(posedge clk); while (!digest_valid);
		checker_h.check_word(digest);
		words_taken++;
	endtask

	// one message of random bytes, bare requests mixed in as noise
	task automatic send_message(input int len, input bit burst);
		msg_item_t m;
		bit        merge_end;
		merge_end = $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				m.data_byte = 8'($urandom);
				m.byte_valid = 1'b0;
				m.end_of_message = 1'b0;
				send_request(m, burst ? 0 : $urandom_range(0, 8));
				random_items++;
			end
			m.data_byte = 8'($urandom);
			m.byte_valid = 1'b1;
			m.end_of_message = merge_end && (i == len - 1);
			send_request(m, burst ? 0 : $urandom_range(0, 8));
			random_items++;
		end
		if (len == 0 || !merge_end) begin
			m.data_byte = 8'($urandom);
			m.byte_valid = 1'b0;
			m.end_of_message = 1'b1;
			send_request(m, burst ? 0 : $urandom_range(0, 8));
			random_items++;
		end
		random_msgs++;
	endtask

	task automatic run_directed();
		msg_item_t m;
		// empty message
		m = '{data_byte: 8'h00, byte_valid: 1'b0, end_of_message: 1'b1};
		send_request(m, 0);
		// bare request, ignored
		m = '{data_byte: 8'hA5, byte_valid: 1'b0, end_of_message: 1'b0};
		send_request(m, 1);
		// single byte with the end mark, both extremes
		m = '{data_byte: 8'h00, byte_valid: 1'b1, end_of_message: 1'b1};
		send_request(m, 0);
		m = '{data_byte: 8'hFF, byte_valid: 1'b1, end_of_message: 1'b1};
		send_request(m, 2);
		// "abc" then a bare end mark
		m = '{data_byte: 8'h61, byte_valid: 1'b1, end_of_message: 1'b0};
		send_request(m, 0);
		m = '{data_byte: 8'h62, byte_valid: 1'b1, end_of_message: 1'b0};
		send_request(m, 0);
		m = '{data_byte: 8'h63, byte_valid: 1'b1, end_of_message: 1'b0};
		send_request(m, 3);
		m = '{data_byte: 8'hFF, byte_valid: 1'b0, end_of_message: 1'b1};
		send_request(m, 0);
	endtask

	task automatic run_random();
		int sel;
		int len;
		while (random_items < RANDOM_ITEMS || random_msgs < 12) begin
			sel = $urandom_range(0, 99);
			// lengths cluster near the padding boundaries
			if (sel < 65) len = $urandom_range(0, 10);
			else if (sel < 95) len = $urandom_range(54, 66);
			else len = $urandom_range(118, 130);
			send_message(len, $urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		checker_h = new();
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		digest_stall = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		fork
			forever begin
				if (words_taken == HOLD_AT_WORD) take_word(HOLD_CYCLES);
				else if ((words_taken / 30) % 3 == 1) take_word(0);
				else take_word($urandom_range(0, 8));
			end
		join_none
		run_directed();
		run_random();
		@(negedge clk);
		msg_valid <= 1'b0;
		while (checker_h.expected_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (checker_h.expected_words.size() != 0) checker_h.errors++;
		if (checker_h.errors == 0) $display("sha1_message_digest test passed");
		else $display("sha1_message_digest test failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/smd_pkg.sv
rtl/smd_round.sv
rtl/sha1_message_digest.sv
bench/tb.sv
